// ===== src/mask_pixel_boolean_combine_top_defines.svh =====
// Assertion macros shared by the mask combine block.
`ifndef MASK_PIXEL_BOOLEAN_COMBINE_TOP_DEFINES_SVH
`define MASK_PIXEL_BOOLEAN_COMBINE_TOP_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define MPBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mpbc same-cycle check failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define MPBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mpbc next-cycle check failed");

`endif

// ===== src/mpbc_pkg.sv =====
// Package with mode and register index codes for the mask combine block.
package mpbc_pkg;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned MODE_W    = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_COPY      = 3'd0,
    MODE_UNION     = 3'd1,
    MODE_INTERSECT = 3'd2,
    MODE_DIFF      = 3'd3,
    MODE_EXCL      = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COMBINE_MODE = 2'd0,
    REG_INVERT_SHAPE = 2'd1,
    REG_OPACITY      = 2'd2
  } cfg_reg_e;

endpackage

// ===== src/mpbc_if.sv =====
// Valid/ready stream interfaces for pixel words in and combined words out.
interface mpbc_in_if #(
  parameter int unsigned VALUE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] current_value;
  logic [VALUE_BITS-1:0] shape_value;
  logic                  last_pixel;

  modport source (output valid, current_value, shape_value, last_pixel, input ready);
  modport sink   (input valid, current_value, shape_value, last_pixel, output ready);
endinterface

interface mpbc_out_if #(
  parameter int unsigned VALUE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] combined_value;
  logic                  last_out;

  modport source (output valid, combined_value, last_out, input ready);
  modport sink   (input valid, combined_value, last_out, output ready);
endinterface

// ===== src/mpbc_qmul.sv =====
// Q1.x fractional multiply with round-half-up back to the value width.
module mpbc_qmul import mpbc_pkg::*; #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic [VALUE_BITS-1:0] a_i,
  input  logic [VALUE_BITS-1:0] b_i,
  output logic [VALUE_BITS-1:0] y_o
);

  localparam int unsigned PW = 2 * VALUE_BITS;
  localparam logic [PW-1:0] HALF = PW'(1) << (VALUE_BITS - 2);

  logic [PW-1:0] prod;

  // inputs stay within 0..ONE, so the rounded result fits in VALUE_BITS
  assign prod = (PW'(a_i) * PW'(b_i)) + HALF;
  assign y_o  = prod[PW-2 -: VALUE_BITS];

endmodule

// ===== src/mask_pixel_boolean_combine_top.sv =====
// Top level of the per-pixel fuzzy mask combine pipeline.
//
// Usage: pixel words enter on in_i (running value, shape value, last flag) and
// combined words leave on out_o with the last flag carried along. Both are
// valid/ready channels; a word moves when valid and ready are high together.
// Values are unsigned Q1.(VALUE_BITS-1), with one at 2^(VALUE_BITS-1); inputs
// above one are clamped to one.
// Each word passes four register stages: clamp and invert, opacity multiply,
// cross products, mode select. Throughput: one word per clock unless out_o.ready
// stalls the pipeline; pixels are independent.
// Configuration (combine mode, invert, opacity) is written on cfg_we_i; the user
// must write it only while the pipeline is empty, which the block itself does
// not enforce. Writes to index 3 are dropped.
// Reset: all stages empty, mode copy, no invert, opacity one.
// Stall: when out_o.ready is low, words back up stage by stage and in_i.ready
// drops only once all four stages hold a word; nothing is lost or repeated.
`include "mask_pixel_boolean_combine_top_defines.svh"

module mask_pixel_boolean_combine_top import mpbc_pkg::*; #(
  parameter int unsigned VALUE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [VALUE_BITS-1:0] cfg_data_i,
  mpbc_in_if.sink               in_i,
  mpbc_out_if.source            out_o
);

  localparam int unsigned W = VALUE_BITS;
  localparam logic [W-1:0] ONE = W'(1) << (W - 1);

  // configuration registers
  logic [MODE_W-1:0] mode_q;
  logic              invert_q;
  logic [W-1:0]      opacity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_W'(MODE_COPY);
      invert_q  <= 1'b0;
      opacity_q <= ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_COMBINE_MODE: mode_q    <= cfg_data_i[MODE_W-1:0];
        REG_INVERT_SHAPE: invert_q  <= cfg_data_i[0];
        REG_OPACITY:      opacity_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage valids and enables
  logic v1_q, v2_q, v3_q, v4_q;
  logic en1, en2, en3, en4;

  assign en4 = !v4_q || out_o.ready;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;
  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // stage 1: clamp to one and invert the shape
  logic [W-1:0] c_sat, s_sat, op_sat, s_inv;
  logic [W-1:0] c1_q, s1_q, op1_q;
  logic         last1_q;

  assign c_sat  = (in_i.current_value > ONE) ? ONE : in_i.current_value;
  assign s_sat  = (in_i.shape_value > ONE) ? ONE : in_i.shape_value;
  assign op_sat = (opacity_q > ONE) ? ONE : opacity_q;
  assign s_inv  = invert_q ? (ONE - s_sat) : s_sat;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      c1_q    <= c_sat;
      s1_q    <= s_inv;
      op1_q   <= op_sat;
      last1_q <= in_i.last_pixel;
    end
  end

  // stage 2: scale by opacity
  logic [W-1:0] m_d;
  logic [W-1:0] c2_q, m2_q;
  logic         last2_q;

  mpbc_qmul #(.VALUE_BITS(W)) u_mul_op (
    .a_i(op1_q),
    .b_i(s1_q),
    .y_o(m_d)
  );

  always_ff @(posedge clk_i) begin
    if (en2) begin
      c2_q    <= c1_q;
      m2_q    <= m_d;
      last2_q <= last1_q;
    end
  end

  // stage 3: cross products for difference and exclusion
  logic [W-1:0] x1_d, x2_d;
  logic [W-1:0] c3_q, m3_q, x1_q, x2_q;
  logic         last3_q;

  mpbc_qmul #(.VALUE_BITS(W)) u_mul_x1 (
    .a_i(ONE - c2_q),
    .b_i(m2_q),
    .y_o(x1_d)
  );

  mpbc_qmul #(.VALUE_BITS(W)) u_mul_x2 (
    .a_i(c2_q),
    .b_i(ONE - m2_q),
    .y_o(x2_d)
  );

  always_ff @(posedge clk_i) begin
    if (en3) begin
      c3_q    <= c2_q;
      m3_q    <= m2_q;
      x1_q    <= x1_d;
      x2_q    <= x2_d;
      last3_q <= last2_q;
    end
  end

  // stage 4: pick the result by mode
  logic         both;
  logic [W-1:0] max_cm, min_cm, max_x, r_d;
  logic [W-1:0] r4_q;
  logic         last4_q;

  assign both   = (c3_q != '0) && (m3_q != '0);
  assign max_cm = (c3_q > m3_q) ? c3_q : m3_q;
  assign min_cm = (c3_q < m3_q) ? c3_q : m3_q;
  assign max_x  = (x1_q > x2_q) ? x1_q : x2_q;

  always_comb begin
    unique case (mode_e'(mode_q))
      MODE_UNION:     r_d = max_cm;
      MODE_INTERSECT: r_d = min_cm;
      MODE_DIFF:      r_d = both ? x2_q : c3_q;
      MODE_EXCL:      r_d = both ? max_x : max_cm;
      default:        r_d = m3_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en4) begin
      r4_q    <= r_d;
      last4_q <= last3_q;
    end
  end

  assign out_o.valid          = v4_q;
  assign out_o.combined_value = r4_q;
  assign out_o.last_out       = last4_q;

  `MPBC_ASSERT_NXT(a_accept_fills_s1, in_i.valid && in_i.ready, v1_q)
  `MPBC_ASSERT_IMP(a_result_in_range, out_o.valid, out_o.combined_value <= ONE)
  `MPBC_ASSERT_IMP(a_full_blocks_input, v1_q && v2_q && v3_q && v4_q && !out_o.ready,
                   !in_i.ready)

endmodule

// ===== tb/testbench.sv =====
// Testbench for the mask combine pipeline: directed table, then random phases checked by a predictor.
`timescale 1ns / 1ps

module testbench;
  import mpbc_pkg::*;

  localparam int unsigned VB           = 16;
  localparam int unsigned PIPE_DEPTH   = 4;
  localparam int unsigned RANDOM_ITEMS = 700;
  localparam int unsigned TABLE_ROWS   = 25;

  typedef logic [VB-1:0] q_t;

  localparam q_t ONE  = q_t'(1) << (VB - 1);
  localparam q_t FULL = '1;
  localparam longint unsigned ONE_L  = longint'(1) << (VB - 1);
  localparam longint unsigned HALF_L = longint'(1) << (VB - 2);

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_SPARE_5 = 3'd5;
  localparam logic [MODE_W-1:0]    MODE_SPARE_6 = 3'd6;
  localparam logic [MODE_W-1:0]    MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    q_t   value;
    logic last;
  } pixel_word_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              inv;
    q_t                opac;
    logic              junk;
    q_t                cur;
    q_t                shp;
    logic              last;
    logic              typed;
    q_t                want;
  } directed_row_t;

  // mode, invert, opacity, junk write, current, shape, last, typed, expected
  directed_row_t directed_rows [TABLE_ROWS] = '{
    '{MODE_COPY,      1'b0, ONE,      1'b0, 16'd0,     ONE,       1'b0, 1'b1, ONE},
    '{MODE_COPY,      1'b0, ONE,      1'b0, ONE,       16'd0,     1'b0, 1'b1, 16'd0},
    '{MODE_COPY,      1'b0, ONE,      1'b0, 16'd0,     FULL,      1'b1, 1'b1, ONE},
    '{MODE_COPY,      1'b0, ONE,      1'b1, 16'd0,     16'd1234,  1'b0, 1'b1, 16'd1234},
    '{MODE_UNION,     1'b0, ONE,      1'b0, 16'h8001,  16'd100,   1'b0, 1'b1, ONE},
    '{MODE_UNION,     1'b0, ONE,      1'b0, 16'd1000,  16'd2000,  1'b0, 1'b0, 16'd0},
    '{MODE_INTERSECT, 1'b0, ONE,      1'b0, FULL,      FULL,      1'b0, 1'b1, ONE},
    '{MODE_INTERSECT, 1'b0, ONE,      1'b0, 16'd5000,  16'd300,   1'b1, 1'b0, 16'd0},
    '{MODE_DIFF,      1'b0, ONE,      1'b0, 16'd0,     16'd20000, 1'b0, 1'b1, 16'd0},
    '{MODE_DIFF,      1'b0, ONE,      1'b0, 16'd20000, 16'd0,     1'b0, 1'b1, 16'd20000},
    '{MODE_DIFF,      1'b0, ONE,      1'b0, ONE,       ONE,       1'b0, 1'b1, 16'd0},
    '{MODE_DIFF,      1'b0, ONE,      1'b0, 16'd12345, 16'd6789,  1'b0, 1'b0, 16'd0},
    '{MODE_EXCL,      1'b0, ONE,      1'b0, 16'd0,     16'd7000,  1'b0, 1'b1, 16'd7000},
    '{MODE_EXCL,      1'b0, ONE,      1'b0, ONE,       ONE,       1'b0, 1'b1, 16'd0},
    '{MODE_EXCL,      1'b0, ONE,      1'b0, 16'd10000, 16'd20000, 1'b1, 1'b0, 16'd0},
    '{MODE_COPY,      1'b1, ONE,      1'b0, 16'd0,     16'd0,     1'b0, 1'b1, ONE},
    '{MODE_COPY,      1'b1, ONE,      1'b0, 16'd0,     FULL,      1'b0, 1'b1, 16'd0},
    '{MODE_COPY,      1'b0, 16'd0,    1'b0, 16'd0,     ONE,       1'b0, 1'b1, 16'd0},
    '{MODE_UNION,     1'b0, 16'd0,    1'b0, 16'd500,   ONE,       1'b0, 1'b1, 16'd500},
    '{MODE_COPY,      1'b0, FULL,     1'b0, 16'd0,     16'd16384, 1'b0, 1'b1, 16'd16384},
    '{MODE_COPY,      1'b0, 16'd16384, 1'b0, 16'd0,    16'd1,     1'b0, 1'b1, 16'd1},
    '{MODE_COPY,      1'b0, 16'd16384, 1'b0, 16'd0,    16'd3,     1'b0, 1'b0, 16'd0},
    '{MODE_SPARE_5,   1'b0, ONE,      1'b0, 16'd0,     16'd4321,  1'b0, 1'b0, 16'd0},
    '{MODE_SPARE_6,   1'b1, ONE,      1'b0, 16'd9,     16'd4321,  1'b0, 1'b0, 16'd0},
    '{MODE_SPARE_7,   1'b0, ONE,      1'b0, FULL,      16'd0,     1'b1, 1'b0, 16'd0}
  };

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  q_t                   cfg_data;

  // predictor copy of the configuration registers
  logic [MODE_W-1:0] mode_reg;
  logic              invert_reg;
  q_t                opacity_reg;

  pixel_word_t combined_due [$];
  int unsigned mismatches;
  int unsigned items_sent;
  bit          steady;

  mpbc_in_if  #(.VALUE_BITS(VB)) pix_in ();
  mpbc_out_if #(.VALUE_BITS(VB)) pix_out ();

  mask_pixel_boolean_combine_top #(.VALUE_BITS(VB)) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (pix_in),
    .out_o      (pix_out)
  );

  function automatic longint unsigned clamp_one(q_t v);
    return (longint'(v) > ONE_L) ? ONE_L : longint'(v);
  endfunction

  function automatic longint unsigned round_mul(longint unsigned a, longint unsigned b);
    return (a * b + HALF_L) >> (VB - 1);
  endfunction

  function automatic q_t blend_pixel(q_t cur_raw, q_t shp_raw);
    longint unsigned c;
    longint unsigned s;
    longint unsigned m;
    longint unsigned r;
    longint unsigned x1;
    longint unsigned x2;
    bit              both;
    c = clamp_one(cur_raw);
    s = clamp_one(shp_raw);
    if (invert_reg) begin
      s = ONE_L - s;
    end
    m = round_mul(clamp_one(opacity_reg), s);
    both = (c != 0) && (m != 0);
    case (mode_reg)
      MODE_UNION: begin
        r = (c > m) ? c : m;
      end
      MODE_INTERSECT: begin
        r = (c < m) ? c : m;
      end
      MODE_DIFF: begin
        r = both ? round_mul(c, ONE_L - m) : c;
      end
      MODE_EXCL: begin
        if (both) begin
          x1 = round_mul(ONE_L - c, m);
          x2 = round_mul(c, ONE_L - m);
          r  = (x1 > x2) ? x1 : x2;
        end else begin
          r = (c > m) ? c : m;
        end
      end
      default: begin
        r = m;
      end
    endcase
    if (r > ONE_L) begin
      r = ONE_L;
    end
    return q_t'(r);
  endfunction

  // mostly short holds, a few long ones; none during steady phases
  function automatic int unsigned hold_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) begin
      return 0;
    end
    if (roll < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // weight the corners: zero, one, just below one, the smallest step, above one
  function automatic q_t pick_value();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      return '0;
    end
    if (roll < 16) begin
      return ONE;
    end
    if (roll < 22) begin
      return ONE - 1'b1;
    end
    if (roll < 26) begin
      return q_t'(1);
    end
    if (roll < 34) begin
      return q_t'($urandom_range(int'(ONE) + 1, int'(FULL)));
    end
    return q_t'($urandom_range(0, int'(ONE)));
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, q_t data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    case (idx)
      REG_COMBINE_MODE: mode_reg    = data[MODE_W-1:0];
      REG_INVERT_SHAPE: invert_reg  = data[0];
      REG_OPACITY:      opacity_reg = data;
      default: ;
    endcase
  endtask

  task automatic wait_pipeline_empty();
    @(negedge clk);
    pix_in.valid <= 1'b0;
    while (combined_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic push_pixel(q_t cur, q_t shp, logic last, logic typed, q_t want);
    int unsigned gap;
    pixel_word_t word;
    gap = hold_len();
    if (gap != 0) begin
      @(negedge clk);
      pix_in.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pix_in.valid         <= 1'b1;
    pix_in.current_value <= cur;
    pix_in.shape_value   <= shp;
    pix_in.last_pixel    <= last;
    do @(posedge clk); while (!pix_in.ready);
    word.value = typed ? want : blend_pixel(cur, shp);
    word.last  = last;
    combined_due.push_back(word);
    items_sent++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("testbench: FAIL");
    $finish;
  end

  // output side: bursts of ready with random stalls in between
  initial begin : out_pacing
    int unsigned burst;
    int unsigned stall;
    pix_out.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      burst = $urandom_range(1, 40);
      repeat (burst) @(negedge clk) pix_out.ready <= 1'b1;
      stall = hold_len();
      repeat (stall) @(negedge clk) pix_out.ready <= 1'b0;
    end
  end

  always @(posedge clk) begin : out_check
    pixel_word_t want;
    if (rst_n && pix_out.valid && pix_out.ready) begin
      if (combined_due.size() == 0) begin
        $error("unexpected word: combined_value %0d last_out %0b",
               pix_out.combined_value, pix_out.last_out);
        mismatches++;
      end else begin
        want = combined_due.pop_front();
        if (pix_out.combined_value !== want.value) begin
          $error("combined_value: expected %0d, got %0d", want.value, pix_out.combined_value);
          mismatches++;
        end
        if (pix_out.last_out !== want.last) begin
          $error("last_out: expected %0b, got %0b", want.last, pix_out.last_out);
          mismatches++;
        end
      end
    end
  end

  initial begin : stimulus
    directed_row_t row;
    q_t            mode_word;
    int unsigned   phase_len;
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_idx              = REG_COMBINE_MODE;
    cfg_data             = '0;
    pix_in.valid         = 1'b0;
    pix_in.current_value = '0;
    pix_in.shape_value   = '0;
    pix_in.last_pixel    = 1'b0;
    mode_reg             = MODE_COPY;
    invert_reg           = 1'b0;
    opacity_reg          = ONE;
    mismatches           = 0;
    items_sent           = 0;
    steady               = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.mode != mode_reg || row.inv != invert_reg || row.opac != opacity_reg ||
          row.junk) begin
        wait_pipeline_empty();
        if (row.mode != mode_reg) begin
          write_reg(REG_COMBINE_MODE, q_t'(row.mode));
        end
        if (row.inv != invert_reg) begin
          write_reg(REG_INVERT_SHAPE, q_t'(row.inv));
        end
        if (row.opac != opacity_reg) begin
          write_reg(REG_OPACITY, row.opac);
        end
        // unmapped index must leave every register alone
        if (row.junk) begin
          write_reg(REG_UNUSED, FULL);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
      end
      push_pixel(row.cur, row.shp, row.last, row.typed, row.want);
    end

    while (items_sent < TABLE_ROWS + RANDOM_ITEMS) begin
      wait_pipeline_empty();
      steady = ($urandom_range(0, 3) == 0);
      // junk in the upper bits of the narrow registers must be dropped
      mode_word = q_t'($urandom);
      if ($urandom_range(0, 9) == 0) begin
        mode_word[MODE_W-1:0] = MODE_W'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
      end else begin
        mode_word[MODE_W-1:0] = MODE_W'($urandom_range(MODE_COPY, MODE_EXCL));
      end
      write_reg(REG_COMBINE_MODE, mode_word);
      write_reg(REG_INVERT_SHAPE, q_t'($urandom));
      write_reg(REG_OPACITY, pick_value());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_UNUSED, q_t'($urandom));
      end
      @(negedge clk);
      cfg_we <= 1'b0;
      phase_len = $urandom_range(15, 80);
      repeat (phase_len) begin
        push_pixel(pick_value(), pick_value(), ($urandom_range(0, 7) == 0), 1'b0, '0);
      end
    end

    steady = 1'b0;
    wait_pipeline_empty();
    if (mismatches == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
